/* sv/qrwlt_pkg.sv */
// ----------------------------------------------------------------------------
// qrwlt_pkg
// Shared types and codes for the queued reader/writer lock table.
// ----------------------------------------------------------------------------
package qrwlt_pkg;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ABORT   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_GRANT  = 1'b1;

    localparam int         CNT_W     = 7;
    localparam logic [6:0] COUNT_MAX = 7'd127;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECODE,
        S_ROUTE,
        S_PREV_RD,
        S_PREV_CHK,
        S_ACQ_WR,
        S_ACQ_FULL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NOT_FOUND,
        S_SHIFT_RD,
        S_SHIFT_CHK,
        S_GRANT_CNT,
        S_LEN_WR,
        S_STAT_RD,
        S_STAT_CHK,
        S_EMIT_STAT,
        S_EMIT_GRANT
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic latch_len;
        logic prev_chk;
        logic prev_rd;
        logic acq_wr;
        logic acq_full;
        logic scan_rd;
        logic scan_chk;
        logic not_found;
        logic shift_rd;
        logic shift_chk;
        logic grant_cnt;
        logic len_wr;
        logic stat_chk;
        logic emit_stat;
        logic emit_grant;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_acq;
        logic is_rel;
        logic full;
        logic take_prev;
        logic scan_end;
        logic scan_hit;
        logic shift_end;
        logic grant_real;
        logic no_grants;
        logic last_grant;
    } dp_stat_t;

endpackage

/* sv/qrwlt_ctrl.sv */
// ----------------------------------------------------------------------------
// qrwlt_ctrl
// Sequencer for the lock table: steps each request through lookup, queue
// scan and shift, hand-over grants and result transfers.
// ----------------------------------------------------------------------------
module qrwlt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  qrwlt_pkg::dp_stat_t stat,
    output qrwlt_pkg::dp_cmd_t  cmd,
    output logic               busy
);
    import qrwlt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:      if (stat.clear_done) state_next = S_IDLE;
            S_IDLE:       if (start) state_next = S_LOOKUP;
            S_LOOKUP:     state_next = S_DECODE;
            S_DECODE:     state_next = S_ROUTE;
            S_ROUTE:
            begin
                if (stat.is_acq)
                begin
                    if (stat.full)
                        state_next = S_ACQ_FULL;
                    else if (stat.take_prev)
                        state_next = S_PREV_RD;
                    else
                        state_next = S_ACQ_WR;
                end
                else if (stat.is_rel)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_IDLE;
            end
            S_PREV_RD:    state_next = S_PREV_CHK;
            S_PREV_CHK:   state_next = S_ACQ_WR;
            S_ACQ_WR:     state_next = S_EMIT_STAT;
            S_ACQ_FULL:   state_next = S_EMIT_STAT;
            S_SCAN_RD:    state_next = stat.scan_end ? S_NOT_FOUND : S_SCAN_CHK;
            S_SCAN_CHK:   state_next = stat.scan_hit ? S_SHIFT_RD : S_SCAN_RD;
            S_NOT_FOUND:  state_next = S_EMIT_STAT;
            S_SHIFT_RD:   state_next = stat.shift_end ? S_LEN_WR : S_SHIFT_CHK;
            S_SHIFT_CHK:  state_next = stat.grant_real ? S_GRANT_CNT : S_SHIFT_RD;
            S_GRANT_CNT:  state_next = S_SHIFT_RD;
            S_LEN_WR:     state_next = S_STAT_RD;
            S_STAT_RD:    state_next = S_STAT_CHK;
            S_STAT_CHK:   state_next = S_EMIT_STAT;
            S_EMIT_STAT:  state_next = stat.no_grants ? S_IDLE : S_EMIT_GRANT;
            S_EMIT_GRANT: if (stat.last_grant) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_CLEAR:      cmd.clear      = 1'b1;
            S_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            S_LOOKUP:     ;
            S_DECODE:     cmd.latch_len  = 1'b1;
            S_ROUTE:      ;
            S_PREV_RD:    cmd.prev_rd    = 1'b1;
            S_PREV_CHK:   cmd.prev_chk   = 1'b1;
            S_ACQ_WR:     cmd.acq_wr     = 1'b1;
            S_ACQ_FULL:   cmd.acq_full   = 1'b1;
            S_SCAN_RD:    cmd.scan_rd    = 1'b1;
            S_SCAN_CHK:   cmd.scan_chk   = 1'b1;
            S_NOT_FOUND:  cmd.not_found  = 1'b1;
            S_SHIFT_RD:   cmd.shift_rd   = 1'b1;
            S_SHIFT_CHK:  cmd.shift_chk  = 1'b1;
            S_GRANT_CNT:  cmd.grant_cnt  = 1'b1;
            S_LEN_WR:     cmd.len_wr     = 1'b1;
            S_STAT_RD:    ;
            S_STAT_CHK:   cmd.stat_chk   = 1'b1;
            S_EMIT_STAT:  cmd.emit_stat  = 1'b1;
            S_EMIT_GRANT: cmd.emit_grant = 1'b1;
            default:      ;
        endcase
    end

endmodule

/* sv/qrwlt_datapath.sv */
// ----------------------------------------------------------------------------
// qrwlt_datapath
// Queue entry, queue length and waiting count memories, request registers,
// grant buffer and result drive.
// ----------------------------------------------------------------------------
module qrwlt_datapath #(
    parameter int NUM_RECORDS = 64,
    parameter int QUEUE_DEPTH = 8,
    parameter int NUM_TXNS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  qrwlt_pkg::dp_cmd_t  cmd,
    output qrwlt_pkg::dp_stat_t stat,
    input  logic [1:0]         operation,
    input  logic [5:0]         record_index,
    input  logic [5:0]         txn_id,
    input  logic               write_req,
    input  logic               first_of_txn,
    output logic               result_strobe,
    output logic               kind,
    output logic [5:0]         out_txn,
    output logic [5:0]         out_record,
    output logic               granted,
    output logic               txn_ready,
    output logic [1:0]         status,
    output logic               last
);
    import qrwlt_pkg::*;

    localparam int RW    = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
    localparam int TW    = (NUM_TXNS > 1) ? $clog2(NUM_TXNS) : 1;
    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int EW    = TW + 2;
    localparam int CLR_N = (NUM_RECORDS > NUM_TXNS) ? NUM_RECORDS : NUM_TXNS;
    localparam int CW    = $clog2(CLR_N);

    // reduction of a six-bit index by a constant, built at elaboration
    function automatic logic [383:0] mod_tab(input int m);
        logic [383:0] tab;
        int           r;
        tab = '0;
        r   = 0;
        for (int v = 0; v < 64; v++)
        begin
            tab[v*6 +: 6] = 6'(r);
            r = r + 1;
            if (r == m)
                r = 0;
        end
        return tab;
    endfunction

    localparam logic [383:0] REC_TAB = mod_tab(NUM_RECORDS);
    localparam logic [383:0] TXN_TAB = mod_tab(NUM_TXNS);

    logic [EW-1:0]    ent_mem [NUM_RECORDS << SW];
    logic [LW-1:0]    len_mem [NUM_RECORDS];
    logic [CNT_W-1:0] cnt_mem [NUM_TXNS];

    logic [EW-1:0]    ent_rdata;
    logic [LW-1:0]    len_rdata;
    logic [CNT_W-1:0] cnt_rdata;

    logic [RW+SW-1:0] ent_raddr, ent_waddr;
    logic [EW-1:0]    ent_wdata;
    logic             ent_we;
    logic [RW-1:0]    len_waddr;
    logic [LW-1:0]    len_wdata;
    logic             len_we;
    logic [TW-1:0]    cnt_raddr, cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata;
    logic             cnt_we;

    logic [1:0]       op_reg;
    logic [RW-1:0]    rec_reg;
    logic [TW-1:0]    txn_reg;
    logic             wr_reg;
    logic             first_reg;
    logic [LW-1:0]    len_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             prev_ok_reg;
    logic [LW-1:0]    idx_reg;
    logic [LW-1:0]    pos_reg;
    logic             gone_wr_reg;
    logic             gactive_reg;
    logic [TW-1:0]    owner_reg;
    logic             st_granted_reg;
    logic             st_ready_reg;
    logic [1:0]       st_code_reg;
    logic [TW-1:0]    gb_txn [QUEUE_DEPTH];
    logic             gb_rdy [QUEUE_DEPTH];
    logic [LW-1:0]    gcnt_reg;
    logic [LW-1:0]    gidx_reg;
    logic [CW-1:0]    clr_reg;

    logic [LW-1:0]    idx_inc;
    logic [LW-1:0]    idx_inc_g;
    logic [LW-1:0]    len_dec;
    logic [SW-1:0]    slot;
    logic [TW-1:0]    e_owner;
    logic             e_wr, e_held;
    logic             ok;
    logic [CNT_W-1:0] cnt_base, cnt_acq;
    logic [CNT_W-1:0] cnt_dec;
    logic             at_pos, g_raw, g_cont;

    assign idx_inc = idx_reg + 1'b1;
    assign len_dec = len_reg - 1'b1;
    assign e_owner = ent_rdata[EW-1:2];
    assign e_wr    = ent_rdata[1];
    assign e_held  = ent_rdata[0];

    assign ok       = (len_reg == '0) || (!wr_reg && prev_ok_reg);
    assign cnt_base = first_reg ? '0 : cnt_reg;
    assign cnt_acq  = (!ok && cnt_base < COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
    assign cnt_dec  = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata;

    assign at_pos = (idx_reg == pos_reg);
    always_comb
    begin
        g_raw  = 1'b0;
        g_cont = 1'b0;
        if (gactive_reg)
        begin
            if (at_pos)
            begin
                if (gone_wr_reg)
                begin
                    g_raw  = 1'b1;
                    g_cont = !e_wr;
                end
                else
                begin
                    g_raw = (pos_reg == '0) && e_wr;
                end
            end
            else
            begin
                g_raw  = !e_wr;
                g_cont = !e_wr;
            end
        end
    end

    // memory addressing
    always_comb
    begin
        if (cmd.prev_rd)
            slot = len_dec[SW-1:0];
        else if (cmd.shift_rd)
            slot = idx_inc[SW-1:0];
        else if (cmd.scan_rd)
            slot = idx_reg[SW-1:0];
        else
            slot = idx_reg[SW-1:0];
    end
    assign ent_raddr = {rec_reg, slot};
    assign cnt_raddr = cmd.shift_chk ? e_owner : txn_reg;

    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = {rec_reg, idx_reg[SW-1:0]};
        ent_wdata = {e_owner, e_wr, e_held | g_raw};
        len_we    = 1'b0;
        len_waddr = rec_reg;
        len_wdata = len_dec;
        cnt_we    = 1'b0;
        cnt_waddr = txn_reg;
        cnt_wdata = cnt_base;
        if (cmd.clear)
        begin
            len_we    = (32'(clr_reg) < NUM_RECORDS);
            len_waddr = RW'(clr_reg);
            len_wdata = '0;
            cnt_we    = (32'(clr_reg) < NUM_TXNS);
            cnt_waddr = TW'(clr_reg);
            cnt_wdata = '0;
        end
        else if (cmd.acq_wr)
        begin
            ent_we    = 1'b1;
            ent_waddr = {rec_reg, len_reg[SW-1:0]};
            ent_wdata = {txn_reg, wr_reg, ok};
            len_we    = 1'b1;
            len_wdata = len_reg + 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = cnt_acq;
        end
        else if (cmd.acq_full)
        begin
            cnt_we = 1'b1;
        end
        else if (cmd.shift_chk)
        begin
            ent_we = 1'b1;
        end
        else if (cmd.grant_cnt)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = owner_reg;
            cnt_wdata = cnt_dec;
        end
        else if (cmd.len_wr)
        begin
            len_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        ent_rdata <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[len_waddr] <= len_wdata;
        len_rdata <= len_mem[rec_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            idx_reg  <= '0;
            gcnt_reg <= '0;
            gidx_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.capture)
                gcnt_reg <= '0;
            if (cmd.latch_len)
                idx_reg <= '0;
            if ((cmd.scan_chk && !stat.scan_hit) || cmd.grant_cnt
                || (cmd.shift_chk && !stat.grant_real))
                idx_reg <= idx_inc;
            if (cmd.grant_cnt)
                gcnt_reg <= gcnt_reg + 1'b1;
            if (cmd.emit_stat)
                gidx_reg <= '0;
            if (cmd.emit_grant)
                gidx_reg <= gidx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            rec_reg   <= RW'(REC_TAB[record_index*6 +: 6]);
            txn_reg   <= TW'(TXN_TAB[txn_id*6 +: 6]);
            wr_reg    <= write_req;
            first_reg <= first_of_txn;
        end
        if (cmd.latch_len)
        begin
            len_reg <= len_rdata;
            cnt_reg <= cnt_rdata;
        end
        if (cmd.prev_chk)
            prev_ok_reg <= !e_wr && e_held;
        if (cmd.acq_wr)
        begin
            st_granted_reg <= ok;
            st_ready_reg   <= (cnt_acq == '0);
            st_code_reg    <= STAT_OK;
        end
        if (cmd.acq_full)
        begin
            st_granted_reg <= 1'b0;
            st_ready_reg   <= (cnt_base == '0);
            st_code_reg    <= STAT_FULL;
        end
        if (cmd.not_found)
        begin
            st_granted_reg <= 1'b0;
            st_ready_reg   <= (cnt_reg == '0);
            st_code_reg    <= STAT_MISSING;
        end
        if (cmd.stat_chk)
        begin
            st_granted_reg <= 1'b0;
            st_ready_reg   <= (cnt_rdata == '0);
            st_code_reg    <= STAT_OK;
        end
        if (cmd.scan_chk && stat.scan_hit)
        begin
            pos_reg     <= idx_reg;
            gone_wr_reg <= e_wr;
            gactive_reg <= e_held;
        end
        if (cmd.shift_chk)
        begin
            gactive_reg <= gactive_reg && g_cont;
            owner_reg   <= e_owner;
        end
        if (cmd.grant_cnt)
        begin
            gb_txn[gcnt_reg[SW-1:0]] <= owner_reg;
            gb_rdy[gcnt_reg[SW-1:0]] <= (cnt_dec == '0);
        end
    end

    assign idx_inc_g = gidx_reg + 1'b1;

    assign stat.clear_done = (32'(clr_reg) == CLR_N - 1);
    assign stat.is_acq     = (op_reg == OP_ACQUIRE);
    assign stat.is_rel     = (op_reg == OP_RELEASE) || (op_reg == OP_ABORT);
    assign stat.full       = (len_reg >= LW'(QUEUE_DEPTH));
    assign stat.take_prev  = !wr_reg && (len_reg != '0);
    assign stat.scan_end   = (idx_reg == len_reg);
    assign stat.scan_hit   = (e_owner == txn_reg);
    assign stat.shift_end  = (idx_inc >= len_reg);
    assign stat.grant_real = g_raw && !e_held;
    assign stat.no_grants  = (gcnt_reg == '0);
    assign stat.last_grant = (idx_inc_g == gcnt_reg);

    assign result_strobe = cmd.emit_stat || cmd.emit_grant;
    assign kind          = cmd.emit_grant ? KIND_GRANT : KIND_STATUS;
    assign out_txn       = cmd.emit_grant ? 6'(gb_txn[gidx_reg[SW-1:0]]) : 6'(txn_reg);
    assign out_record    = 6'(rec_reg);
    assign granted       = cmd.emit_grant ? 1'b1 : st_granted_reg;
    assign txn_ready     = cmd.emit_grant ? gb_rdy[gidx_reg[SW-1:0]] : st_ready_reg;
    assign status        = cmd.emit_grant ? STAT_OK : st_code_reg;
    assign last          = cmd.emit_grant ? stat.last_grant : stat.no_grants;

endmodule

/* sv/queued_rw_lock_table.sv */
// ----------------------------------------------------------------------------
// queued_rw_lock_table
// Per-record FIFO reader/writer lock queues with per-transaction waiting
// counts; grants are handed on when a held entry is released or aborted.
// ----------------------------------------------------------------------------
// After reset the block clears its length and count tables, one entry a
// cycle, with busy high, until every record and transaction entry is
// clear. A request is taken when start is high and busy low; busy stays
// high until the last result of that request has left. An acquire reads
// the queue length and waiting count, checks the tail entry when a read
// joins a non-empty queue, then writes the new entry unless the queue is
// full; a release or abort scans the queue for the transaction's first
// entry, shifts the entries behind it forward, counting each grant, then
// writes the new length and reads the waiting count; one that finds no
// entry gives a missing status; an undefined operation gives no result.
// The queue memory is walked one entry at a time. Results leave one a
// cycle on result_strobe: the request's status first, followed by the
// grants in queue order, with last on the final one. The receiver cannot
// stall, so every result must be taken in the cycle it is shown.
module queued_rw_lock_table #(
    parameter int NUM_RECORDS = 64,
    parameter int QUEUE_DEPTH = 8,
    parameter int NUM_TXNS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [5:0] record_index,
    input  logic [5:0] txn_id,
    input  logic       write_req,
    input  logic       first_of_txn,
    output logic       result_strobe,
    output logic       kind,
    output logic [5:0] out_txn,
    output logic [5:0] out_record,
    output logic       granted,
    output logic       txn_ready,
    output logic [1:0] status,
    output logic       last
);
    import qrwlt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    qrwlt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    qrwlt_datapath #(
        .NUM_RECORDS (NUM_RECORDS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_TXNS    (NUM_TXNS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .record_index  (record_index),
        .txn_id        (txn_id),
        .write_req     (write_req),
        .first_of_txn  (first_of_txn),
        .result_strobe (result_strobe),
        .kind          (kind),
        .out_txn       (out_txn),
        .out_record    (out_record),
        .granted       (granted),
        .txn_ready     (txn_ready),
        .status        (status),
        .last          (last)
    );

endmodule

/* test/tb_queued_rw_lock_table.sv */
// ----------------------------------------------------------------------------
// tb_queued_rw_lock_table
// Self-checking bench for the queued reader/writer lock table: directed lock
// hand-over cases, then random acquire/release/abort/undefined requests in
// bursts, every result checked field by field by a scoreboard predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_queued_rw_lock_table;
    import qrwlt_pkg::*;

    localparam int NREC   = 64;
    localparam int DEPTH  = 8;
    localparam int NTXN   = 64;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    typedef struct {
        logic       kind;
        logic [5:0] txn;
        logic [5:0] rec;
        logic       granted;
        logic       ready;
        logic [1:0] status;
        logic       last;
    } lock_result_t;

    typedef struct {
        logic [5:0] owner;
        logic       wr;
        logic       held;
    } lock_slot_t;

    class lock_scoreboard;
        lock_slot_t   slots[NREC][DEPTH];
        int           qlen[NREC];
        logic [6:0]   wait_cnt[NTXN];
        lock_result_t awaited[$];
        lock_result_t grants[$];
        int           errors;

        function new();
            for (int r = 0; r < NREC; r++)
                qlen[r] = 0;
            for (int t = 0; t < NTXN; t++)
                wait_cnt[t] = '0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function lock_result_t make_res(logic k, logic [5:0] t, logic [5:0] r,
                                        logic g, logic [1:0] s);
            lock_result_t x;
            x.kind    = k;
            x.txn     = t;
            x.rec     = r;
            x.granted = g;
            x.ready   = (wait_cnt[t] == 0);
            x.status  = s;
            x.last    = 1'b0;
            return x;
        endfunction

        function void hand_on(int r, int i);
            logic [5:0] t;
            if (slots[r][i].held)
                return;
            slots[r][i].held = 1'b1;
            t = slots[r][i].owner;
            if (wait_cnt[t] > 0)
                wait_cnt[t]--;
            grants.push_back(make_res(KIND_GRANT, t, r[5:0], 1'b1, STAT_OK));
        endfunction

        // predict the results of one accepted request
        function void note_request(logic [1:0] op, logic [5:0] r, logic [5:0] t,
                                   logic wr, logic first);
            lock_result_t x;
            lock_slot_t   gone;
            logic         ok;
            int           len;
            int           pos;
            len = qlen[r];
            grants.delete();
            if (op == OP_ACQUIRE)
            begin
                if (first)
                    wait_cnt[t] = '0;
                if (len >= DEPTH)
                begin
                    x = make_res(KIND_STATUS, t, r, 1'b0, STAT_FULL);
                    x.last = 1'b1;
                    awaited.push_back(x);
                    return;
                end
                if (wr)
                    ok = (len == 0);
                else
                    ok = (len == 0) || (!slots[r][len-1].wr && slots[r][len-1].held);
                slots[r][len].owner = t;
                slots[r][len].wr    = wr;
                slots[r][len].held  = ok;
                qlen[r] = len + 1;
                if (!ok && wait_cnt[t] < COUNT_MAX)
                    wait_cnt[t]++;
                x = make_res(KIND_STATUS, t, r, ok, STAT_OK);
                x.last = 1'b1;
                awaited.push_back(x);
            end
            else if (op == OP_RELEASE || op == OP_ABORT)
            begin
                pos = len;
                for (int i = 0; i < len; i++)
                    if (pos == len && slots[r][i].owner == t)
                        pos = i;
                if (pos >= len)
                begin
                    x = make_res(KIND_STATUS, t, r, 1'b0, STAT_MISSING);
                    x.last = 1'b1;
                    awaited.push_back(x);
                    return;
                end
                gone = slots[r][pos];
                for (int i = pos; i + 1 < len; i++)
                    slots[r][i] = slots[r][i+1];
                len--;
                qlen[r] = len;
                if (gone.held && pos < len)
                begin
                    if (gone.wr)
                    begin
                        if (slots[r][pos].wr)
                            hand_on(r, pos);
                        else
                            for (int i = pos; i < len && !slots[r][i].wr; i++)
                                hand_on(r, i);
                    end
                    else if (pos == 0 && slots[r][0].wr)
                        hand_on(r, 0);
                end
                x = make_res(KIND_STATUS, t, r, 1'b0, STAT_OK);
                if (grants.size() == 0)
                    x.last = 1'b1;
                else
                    grants[grants.size()-1].last = 1'b1;
                awaited.push_back(x);
                foreach (grants[i])
                    awaited.push_back(grants[i]);
            end
        endfunction

        task check_result(lock_result_t got);
            lock_result_t w;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result txn %0d rec %0d", got.txn, got.rec));
                return;
            end
            w = awaited.pop_front();
            if (got.kind != w.kind)
                report($sformatf("kind %0d, want %0d", got.kind, w.kind));
            if (got.txn != w.txn)
                report($sformatf("out_txn %0d, want %0d", got.txn, w.txn));
            if (got.rec != w.rec)
                report($sformatf("out_record %0d, want %0d", got.rec, w.rec));
            if (got.granted != w.granted)
                report($sformatf("granted %0d, want %0d (txn %0d)", got.granted,
                                 w.granted, w.txn));
            if (got.ready != w.ready)
                report($sformatf("txn_ready %0d, want %0d (txn %0d)", got.ready,
                                 w.ready, w.txn));
            if (got.status != w.status)
                report($sformatf("status %0d, want %0d", got.status, w.status));
            if (got.last != w.last)
                report($sformatf("last %0d, want %0d", got.last, w.last));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] operation = '0;
    logic [5:0] record_index = '0;
    logic [5:0] txn_id = '0;
    logic       write_req = 1'b0;
    logic       first_of_txn = 1'b0;
    logic       result_strobe;
    logic       kind;
    logic [5:0] out_txn;
    logic [5:0] out_record;
    logic       granted;
    logic       txn_ready;
    logic [1:0] status;
    logic       last;

    lock_scoreboard sb = new();
    int burst_left = 0;
    bit no_gaps = 1'b0;

    queued_rw_lock_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .record_index(record_index), .txn_id(txn_id),
        .write_req(write_req), .first_of_txn(first_of_txn),
        .result_strobe(result_strobe), .kind(kind), .out_txn(out_txn),
        .out_record(out_record), .granted(granted), .txn_ready(txn_ready),
        .status(status), .last(last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        lock_result_t got;
        if (rst_n && result_strobe)
        begin
            got.kind    = kind;
            got.txn     = out_txn;
            got.rec     = out_record;
            got.granted = granted;
            got.ready   = txn_ready;
            got.status  = status;
            got.last    = last;
            sb.check_result(got);
        end
    end

    // one request, held until the transfer happens
    task send(logic [1:0] op, logic [5:0] r, logic [5:0] t, logic wr, logic first);
        start        <= 1'b1;
        operation    <= op;
        record_index <= r;
        txn_id       <= t;
        write_req    <= wr;
        first_of_txn <= first;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, r, t, wr, first);
    endtask

    task pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // bursty sender: gaps between bursts unless in a gap-free stretch
    task pace();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 9);
        if (!no_gaps)
            pause($urandom_range(1, 12));
    endtask

    task random_request();
        logic [1:0] op;
        logic [5:0] r;
        logic [5:0] t;
        int         pick;
        pick = $urandom_range(0, 99);
        op = (pick < 50) ? OP_ACQUIRE : (pick < 75) ? OP_RELEASE :
             (pick < 96) ? OP_ABORT : OP_UNDEF;
        r = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
        t = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        if (op != OP_ACQUIRE && sb.qlen[r] > 0 && $urandom_range(0, 9) < 8)
            t = sb.slots[r][$urandom_range(0, sb.qlen[r] - 1)].owner;
        send(op, r, t, 1'($urandom), ($urandom_range(0, 4) == 0));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write then queued readers and a writer; hand-over chain
        send(OP_ACQUIRE, 6'd0, 6'd0, 1'b1, 1'b1);
        send(OP_ACQUIRE, 6'd0, 6'd1, 1'b0, 1'b1);
        send(OP_ACQUIRE, 6'd0, 6'd2, 1'b0, 1'b1);
        send(OP_ACQUIRE, 6'd0, 6'd3, 1'b1, 1'b1);
        send(OP_ACQUIRE, 6'd0, 6'd4, 1'b0, 1'b1);
        pause(3);
        send(OP_RELEASE, 6'd0, 6'd0, 1'b0, 1'b0);
        send(OP_RELEASE, 6'd0, 6'd1, 1'b0, 1'b0);
        send(OP_ABORT,   6'd0, 6'd2, 1'b0, 1'b0);
        send(OP_RELEASE, 6'd0, 6'd3, 1'b0, 1'b0);
        // unheld abort, missing entry, undefined operation
        send(OP_ACQUIRE, 6'd1, 6'd5, 1'b0, 1'b1);
        send(OP_ACQUIRE, 6'd1, 6'd6, 1'b1, 1'b0);
        send(OP_ABORT,   6'd1, 6'd6, 1'b0, 1'b0);
        send(OP_ABORT,   6'd1, 6'd9, 1'b0, 1'b0);
        send(OP_UNDEF,   6'd1, 6'd5, 1'b1, 1'b1);
        // full queue at the top record, duplicate owner
        for (int i = 0; i < DEPTH + 1; i++)
            send(OP_ACQUIRE, 6'd63, 6'd63, i[0], (i == 0));
        send(OP_RELEASE, 6'd63, 6'd63, 1'b0, 1'b0);
        drain();

        for (int n = 0; n < 106; n++)
        begin
            if (n == 40)
                no_gaps = 1'b1;
            if (n == 70)
            begin
                no_gaps = 1'b0;
                drain();
            end
            random_request();
            pace();
        end

        drain();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("queued_rw_lock_table test passed");
        else
            $display("queued_rw_lock_table test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("queued_rw_lock_table test failed");
        $finish;
    end

endmodule
